@@ rtl/hgb_pkg.sv @@
// ---------------------------------------------------------------------------
// hgb_pkg: shared types and constants for the horizontal Gaussian blur
// Pixel and result transaction formats, configuration layout, window sizing.
// ---------------------------------------------------------------------------
package hgb_pkg;

  localparam int MAX_RADIUS     = 6;
  localparam int MAX_ROW_LENGTH = 4096;

  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int ROW_CNT_W  = $clog2(MAX_ROW_LENGTH);
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int POS_W      = $clog2(WIN_DEPTH + 1);

  localparam int PIX_W      = 8;
  localparam int WEIGHT_W   = 17;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = PIX_W + WEIGHT_W;
  localparam int SUM_W      = PROD_W + $clog2(WIN_DEPTH);
  localparam int TREE_N     = 1 << $clog2(WIN_DEPTH);

  localparam int NUM_TAPS   = 7;
  localparam int TAP_IDX_W  = $clog2(NUM_TAPS);
  localparam int CFG_RAD_W  = 3;

  localparam logic [WEIGHT_W-1:0] UNIT_WEIGHT = WEIGHT_W'(1 << FRAC_BITS);

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_BLUR_RADIUS  = 3'd0,
    REG_TAP_WEIGHT_0 = 3'd1,
    REG_TAP_WEIGHT_1 = 3'd2,
    REG_TAP_WEIGHT_2 = 3'd3,
    REG_TAP_WEIGHT_3 = 3'd4,
    REG_TAP_WEIGHT_4 = 3'd5,
    REG_TAP_WEIGHT_5 = 3'd6,
    REG_TAP_WEIGHT_6 = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic             row_end;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             row_last;
    logic             burst_last;
  } pixel_out_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [PROD_W-1:0] red;
    logic [PROD_W-1:0] green;
    logic [PROD_W-1:0] blue;
  } prod_rgb_t;

  typedef struct packed {
    logic [RAD_W-1:0]                   radius;
    logic [NUM_TAPS-1:0][WEIGHT_W-1:0]  weight;
  } blur_cfg_t;

  // One pending output: which window slot is the centre pixel, how many
  // window slots belong to the current row, and whether this is a flush.
  typedef struct packed {
    logic [RAD_W-1:0] centre;
    logic [POS_W-1:0] n_clip;
    logic             flush;
  } job_t;

  typedef struct packed {
    logic row_last;
    logic burst_last;
  } tag_t;

endpackage

@@ rtl/hgb_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// hgb_cfg_regs: APB configuration registers
// Blur radius and the seven Q1.16 tap weights, with read back.
// ---------------------------------------------------------------------------
module hgb_cfg_regs
  import hgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output blur_cfg_t             cfg
);

  logic [CFG_RAD_W-1:0]               radius_reg;
  logic [NUM_TAPS-1:0][WEIGHT_W-1:0]  weight_reg;
  reg_idx_t                           idx;
  logic                               wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_reg <= '0;
      // Centre weight resets to one, every other tap to zero.
      weight_reg <= (NUM_TAPS*WEIGHT_W)'(UNIT_WEIGHT);
    end else if (wr_en) begin
      unique case (idx)
        REG_BLUR_RADIUS:  radius_reg    <= pwdata[CFG_RAD_W-1:0];
        REG_TAP_WEIGHT_0: weight_reg[0] <= pwdata[WEIGHT_W-1:0];
        REG_TAP_WEIGHT_1: weight_reg[1] <= pwdata[WEIGHT_W-1:0];
        REG_TAP_WEIGHT_2: weight_reg[2] <= pwdata[WEIGHT_W-1:0];
        REG_TAP_WEIGHT_3: weight_reg[3] <= pwdata[WEIGHT_W-1:0];
        REG_TAP_WEIGHT_4: weight_reg[4] <= pwdata[WEIGHT_W-1:0];
        REG_TAP_WEIGHT_5: weight_reg[5] <= pwdata[WEIGHT_W-1:0];
        REG_TAP_WEIGHT_6: weight_reg[6] <= pwdata[WEIGHT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BLUR_RADIUS:  prdata = APB_DATA_W'(radius_reg);
      REG_TAP_WEIGHT_0: prdata = APB_DATA_W'(weight_reg[0]);
      REG_TAP_WEIGHT_1: prdata = APB_DATA_W'(weight_reg[1]);
      REG_TAP_WEIGHT_2: prdata = APB_DATA_W'(weight_reg[2]);
      REG_TAP_WEIGHT_3: prdata = APB_DATA_W'(weight_reg[3]);
      REG_TAP_WEIGHT_4: prdata = APB_DATA_W'(weight_reg[4]);
      REG_TAP_WEIGHT_5: prdata = APB_DATA_W'(weight_reg[5]);
      REG_TAP_WEIGHT_6: prdata = APB_DATA_W'(weight_reg[6]);
    endcase
  end

  // Radii above the supported maximum behave as the maximum.
  always_comb begin
    cfg.weight = weight_reg;
    if (radius_reg > CFG_RAD_W'(MAX_RADIUS)) begin
      cfg.radius = RAD_W'(MAX_RADIUS);
    end else begin
      cfg.radius = RAD_W'(radius_reg);
    end
  end

endmodule

@@ rtl/hgb_window.sv @@
// ---------------------------------------------------------------------------
// hgb_window: pixel window, row counter and output sequencer
// Shifts accepted pixels into the window and issues one job per output.
// ---------------------------------------------------------------------------
module hgb_window
  import hgb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  pixel_in_t              pixel,
  input  logic [RAD_W-1:0]       radius,
  input  logic                   prod_ready,
  output logic                   job_valid,
  output job_t                   job,
  output rgb_t [WIN_DEPTH-1:0]   window
);

  logic [ROW_CNT_W-1:0] row_count;
  logic [ROW_CNT_W-1:0] count_inc;
  logic [ROW_CNT_W-1:0] last_pos;
  logic [ROW_CNT_W-1:0] radius_ext;
  logic                 burst_more;
  logic                 job_free;
  logic                 accept;
  logic                 emit;
  job_t                 job_load;
  rgb_t                 pix_rgb;

  // A flush job with more pixels to give keeps the window frozen.
  assign burst_more  = job_valid && job.flush && (job.centre != '0);
  assign job_free    = !job_valid || (prod_ready && !burst_more);
  assign pixel_stall = !job_free;
  assign accept      = pixel_valid && job_free;

  assign count_inc  = (row_count < ROW_CNT_W'(MAX_ROW_LENGTH - 1)) ?
                      row_count + 1'b1 : row_count;
  assign last_pos   = count_inc - 1'b1;
  assign radius_ext = ROW_CNT_W'(radius);
  assign emit       = pixel.row_end || (count_inc > radius_ext);

  assign pix_rgb.red   = pixel.red_in;
  assign pix_rgb.green = pixel.green_in;
  assign pix_rgb.blue  = pixel.blue_in;

  always_comb begin
    job_load.flush = pixel.row_end;
    if (count_inc < ROW_CNT_W'(WIN_DEPTH)) begin
      job_load.n_clip = POS_W'(count_inc);
    end else begin
      job_load.n_clip = POS_W'(WIN_DEPTH);
    end
    // A row no longer than the radius starts its flush at its first pixel.
    if (pixel.row_end && (last_pos < radius_ext)) begin
      job_load.centre = RAD_W'(last_pos);
    end else begin
      job_load.centre = radius;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      job_valid <= 1'b0;
    end else if (accept) begin
      row_count <= pixel.row_end ? '0 : count_inc;
      job_valid <= emit;
    end else if (job_valid && prod_ready && !burst_more) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (accept) begin
      job    <= job_load;
      window <= {window[WIN_DEPTH-2:0], pix_rgb};
    end else if (burst_more && prod_ready) begin
      job.centre <= job.centre - 1'b1;
    end
  end

endmodule

@@ rtl/hgb_taps.sv @@
// ---------------------------------------------------------------------------
// hgb_taps: per-tap weighting stage
// Selects the weight of every window slot and registers the products.
// ---------------------------------------------------------------------------
module hgb_taps
  import hgb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  input  job_t                      job,
  input  rgb_t      [WIN_DEPTH-1:0] window,
  input  blur_cfg_t                 cfg,
  input  logic                      out_ready,
  output logic                      prod_ready,
  output logic                      prod_valid,
  output prod_rgb_t [WIN_DEPTH-1:0] prod,
  output tag_t                      tag
);

  logic [WIN_DEPTH-1:0][POS_W-1:0]    tap_off;
  logic [WIN_DEPTH-1:0]               tap_en;
  logic [WIN_DEPTH-1:0][WEIGHT_W-1:0] wt;
  prod_rgb_t [WIN_DEPTH-1:0]          prod_next;
  logic [POS_W-1:0]                   ctr;
  tag_t                               tag_next;

  assign prod_ready = !prod_valid || out_ready;
  assign ctr        = POS_W'(job.centre);

  // Slot k sits at offset |centre - k| from the centre pixel. Slots past
  // the start of the row or outside the radius contribute nothing.
  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if (ctr >= POS_W'(k)) begin
        tap_off[k] = ctr - POS_W'(k);
      end else begin
        tap_off[k] = POS_W'(k) - ctr;
      end
      tap_en[k] = (tap_off[k] <= POS_W'(cfg.radius)) && (POS_W'(k) < job.n_clip);
      if (!tap_en[k]) begin
        wt[k] = '0;
      end else if (cfg.radius == '0) begin
        wt[k] = UNIT_WEIGHT;
      end else begin
        wt[k] = cfg.weight[tap_off[k][TAP_IDX_W-1:0]];
      end
      prod_next[k].red   = PROD_W'(window[k].red)   * PROD_W'(wt[k]);
      prod_next[k].green = PROD_W'(window[k].green) * PROD_W'(wt[k]);
      prod_next[k].blue  = PROD_W'(window[k].blue)  * PROD_W'(wt[k]);
    end
  end

  assign tag_next.row_last   = job.flush && (job.centre == '0);
  assign tag_next.burst_last = !job.flush || (job.centre == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && job_valid) begin
      prod <= prod_next;
      tag  <= tag_next;
    end
  end

endmodule

@@ rtl/hgb_sum.sv @@
// ---------------------------------------------------------------------------
// hgb_sum: accumulation and output register
// Adds the weighted taps per channel, truncates, saturates, holds the result.
// ---------------------------------------------------------------------------
module hgb_sum
  import hgb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      prod_valid,
  input  prod_rgb_t [WIN_DEPTH-1:0] prod,
  input  tag_t                      tag,
  output logic                      out_ready,
  output logic                      result_valid,
  input  logic                      result_stall,
  output pixel_out_t                result
);

  logic [WIN_DEPTH-1:0][PROD_W-1:0] red_terms;
  logic [WIN_DEPTH-1:0][PROD_W-1:0] green_terms;
  logic [WIN_DEPTH-1:0][PROD_W-1:0] blue_terms;
  pixel_out_t                       result_next;

  function automatic logic [SUM_W-1:0] add_tree(
    input logic [WIN_DEPTH-1:0][PROD_W-1:0] terms
  );
    logic [TREE_N-1:0][SUM_W-1:0] node;
    node = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      node[i] = SUM_W'(terms[i]);
    end
    // Balanced tree, log2 levels deep; each level folds pairs in place.
    for (int w = TREE_N >> 1; w >= 1; w = w >> 1) begin
      for (int i = 0; i < w; i++) begin
        node[i] = node[2*i] + node[2*i+1];
      end
    end
    return node[0];
  endfunction

  function automatic logic [PIX_W-1:0] sat_byte(input logic [SUM_W-1:0] acc);
    if (|acc[SUM_W-1:FRAC_BITS+PIX_W]) begin
      return '1;
    end
    return acc[FRAC_BITS+PIX_W-1:FRAC_BITS];
  endfunction

  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      red_terms[k]   = prod[k].red;
      green_terms[k] = prod[k].green;
      blue_terms[k]  = prod[k].blue;
    end
    result_next.red_out    = sat_byte(add_tree(red_terms));
    result_next.green_out  = sat_byte(add_tree(green_terms));
    result_next.blue_out   = sat_byte(add_tree(blue_terms));
    result_next.row_last   = tag.row_last;
    result_next.burst_last = tag.burst_last;
  end

  assign out_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && prod_valid) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/horizontal_gaussian_blur.sv @@
// ---------------------------------------------------------------------------
// horizontal_gaussian_blur: streaming 1-D horizontal Gaussian blur
// Pixels of a row arrive one per transaction with row_end on the last one.
// Each pixel is given as a symmetric weighted sum of its neighbors within
// blur_radius, per channel, with Q1.16 weights from the register file;
// neighbors outside the row are dropped without renormalizing, and the sum
// is truncated to a byte and saturated at 255. Radius zero passes pixels
// through. One pixel is taken per cycle while pixel_stall is low; a pixel's
// result passes the job, product and result registers after the transaction
// completing its right-hand neighbors. A row_end pixel releases the rest of
// the row, up to radius + 1 results, one per cycle from the single result
// sequencer while result_stall is low, holding off the input meanwhile. The
// user must write registers only while the block is idle; the block does not
// enforce it. No clearing pass runs after reset.
// ---------------------------------------------------------------------------
module horizontal_gaussian_blur
  import hgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_in_t             pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output pixel_out_t            result
);

  blur_cfg_t                 cfg;
  logic                      prod_ready;
  logic                      job_valid;
  job_t                      job;
  rgb_t      [WIN_DEPTH-1:0] window;
  logic                      out_ready;
  logic                      prod_valid;
  prod_rgb_t [WIN_DEPTH-1:0] prod;
  tag_t                      tag;

  hgb_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hgb_window u_window (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .radius      (cfg.radius),
    .prod_ready  (prod_ready),
    .job_valid   (job_valid),
    .job         (job),
    .window      (window)
  );

  hgb_taps u_taps (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (job),
    .window     (window),
    .cfg        (cfg),
    .out_ready  (out_ready),
    .prod_ready (prod_ready),
    .prod_valid (prod_valid),
    .prod       (prod),
    .tag        (tag)
  );

  hgb_sum u_sum (
    .clk          (clk),
    .rst          (rst),
    .prod_valid   (prod_valid),
    .prod         (prod),
    .tag          (tag),
    .out_ready    (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
